// File: hdl/gda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg: shared definitions for the Gregorian date add-days block
// Field widths, calendar constants, sequencer states, status codes and the
// month length helpers used by the datapath.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int MAX_YEAR    = 9999;
	localparam int OFFSET_BITS = 21;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int STATUS_W = 2;

	// Walking year needs one bit of headroom above the input year.
	localparam int YWALK_W = YEAR_W + 1;
	localparam int ALU_W   = (OFFSET_BITS > YWALK_W) ? OFFSET_BITS : YWALK_W;

	localparam int CYCLE_YEARS = 400;
	localparam int CENTURY     = 100;
	localparam int LEAP_DAYS   = 29;
	localparam int MONTHS      = 12;
	localparam int JAN         = 1;
	localparam int FEB         = 2;

	localparam int CYC_W = $clog2(CYCLE_YEARS);

	// Restoring reduction of the year by 400 << k, k from RED_STEPS-1 down to 0.
	localparam int RED_STEPS = 6;
	localparam int RED_W     = $clog2(RED_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_DATE = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = '0;
		endcase
		return len;
	endfunction

	// Leap test on the year's position inside the 400-year cycle.
	function automatic logic is_leap(input logic [CYC_W-1:0] c);
		return (c[1:0] == 2'b00) &&
			(c != CYC_W'(CENTURY)) &&
			(c != CYC_W'(2 * CENTURY)) &&
			(c != CYC_W'(3 * CENTURY));
	endfunction

endpackage

// File: hdl/gda_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_alu: shared subtract and compare unit
// Computes a - b and flags a borrow when b exceeds a. Used for the year
// reduction and for every month step of the walk.
// ----------------------------------------------------------------------------
module gda_alu (
	input  logic [gda_pkg::ALU_W-1:0] a,
	input  logic [gda_pkg::ALU_W-1:0] b,
	output logic [gda_pkg::ALU_W-1:0] diff,
	output logic                      borrow
);
	import gda_pkg::*;

	logic [ALU_W:0] full;

	assign full   = {1'b0, a} - {1'b0, b};
	assign diff   = full[ALU_W-1:0];
	assign borrow = full[ALU_W];

endmodule

// File: hdl/gda_mlen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_mlen: month length lookup
// Gives the number of days of a month, with 29 for February in leap years.
// ----------------------------------------------------------------------------
module gda_mlen (
	input  logic [gda_pkg::CYC_W-1:0]   yr_cyc,
	input  logic [gda_pkg::MONTH_W-1:0] month,
	output logic [gda_pkg::DAY_W-1:0]   dim
);
	import gda_pkg::*;

	assign dim = ((month == MONTH_W'(FEB)) && is_leap(yr_cyc)) ?
		DAY_W'(LEAP_DAYS) : month_len(month);

endmodule

// File: hdl/gregorian_date_add_days_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top: Gregorian date plus signed day offset
// Sequence: the year is reduced modulo 400 in REDUCE, the date is checked in
//   CHECK, then the walk crosses one month per cycle in WALK (up to about
//   34,500 months at the largest offset); an invalid date ends at CHECK.
// Handshake: one transaction at a time, no new start is taken while busy;
//   busy drops the cycle after done.
// Reset: arst_n clears the sequencer to idle; results are not reset.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [gda_pkg::YEAR_W-1:0]          start_year,
	input  logic [gda_pkg::MONTH_W-1:0]         start_month,
	input  logic [gda_pkg::DAY_W-1:0]           start_day,
	input  logic signed [gda_pkg::OFFSET_BITS-1:0] day_offset,
	output logic                                done,
	output logic [gda_pkg::YEAR_W-1:0]          result_year,
	output logic [gda_pkg::MONTH_W-1:0]         result_month,
	output logic [gda_pkg::DAY_W-1:0]           result_day,
	output logic [gda_pkg::STATUS_W-1:0]        status
);
	import gda_pkg::*;

	// Sequencer
	state_t state_q, state_d;

	// Captured transaction (passed through on any error)
	logic [YEAR_W-1:0]  y_in_q;
	logic [MONTH_W-1:0] m_in_q;
	logic [DAY_W-1:0]   d_in_q;

	// Walk state
	logic [YWALK_W-1:0]     y_q;
	logic [MONTH_W-1:0]     m_q;
	logic [DAY_W-1:0]       d_q;
	logic [OFFSET_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   fresh_q;   // d_q still holds the start day
	logic [CYC_W-1:0]       yc_q;      // year position inside 400-year cycle
	logic [YEAR_W-1:0]      rem_q;     // year being reduced modulo 400
	logic [RED_W-1:0]       red_k_q;

	// Result registers
	logic [YEAR_W-1:0]  res_year_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [DAY_W-1:0]   res_day_q;
	status_t            status_q;

	// Datapath signals
	logic [DAY_W-1:0]   dim;
	logic [DAY_W-1:0]   eff_d;
	logic [DAY_W-1:0]   gap;
	logic [DAY_W-1:0]   end_d;
	logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
	logic               alu_borrow;
	logic               adv;
	logic               wrap_fail;
	logic               over_max;
	logic               date_bad;
	logic [YWALK_W-1:0] y_up, y_dn;
	logic [YEAR_W-1:0]  rem_next;
	logic               fin;
	status_t            fin_st;

	gda_mlen u_mlen (
		.yr_cyc (yc_q),
		.month  (m_q),
		.dim    (dim)
	);

	gda_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	// Effective day: the start day on the first step, then 0 going forward
	// (start of the next month) or the full length going back (its last day).
	assign eff_d = fresh_q ? d_q : (neg_q ? dim : '0);
	assign gap   = dim - eff_d;

	// Share the subtractor between the year reduction and the month walk.
	always_comb begin
		alu_a = ALU_W'(mag_q);
		alu_b = neg_q ? ALU_W'(eff_d) : ALU_W'(gap);
		if (state_q == ST_REDUCE) begin
			alu_a = ALU_W'(rem_q);
			alu_b = ALU_W'(CYCLE_YEARS) << red_k_q;
		end
	end

	// Forward: step while remaining days exceed the gap to month end.
	// Backward: step while remaining days reach back past day one.
	assign adv = neg_q ? !alu_borrow : (!alu_borrow && (alu_diff != '0));

	assign y_up      = y_q + 1'b1;
	assign y_dn      = y_q - 1'b1;
	assign wrap_fail = neg_q ?
		((m_q == MONTH_W'(JAN)) && (y_q == YWALK_W'(1))) :
		((m_q == MONTH_W'(MONTHS)) && (32'(y_up) > 32'(MAX_YEAR)));
	assign over_max  = 32'(y_q) > 32'(MAX_YEAR);

	// Remaining days fit inside the current month when the walk stops.
	assign end_d = neg_q ? (eff_d - mag_q[DAY_W-1:0]) : (eff_d + mag_q[DAY_W-1:0]);

	assign rem_next = alu_borrow ? rem_q : alu_diff[YEAR_W-1:0];

	assign date_bad = (y_in_q == '0) ||
		(m_in_q == '0) || (m_in_q > MONTH_W'(MONTHS)) ||
		(d_in_q == '0) || (d_in_q > dim);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		fin_st  = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_k_q == '0) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (date_bad) begin
					fin     = 1'b1;
					fin_st  = STAT_BAD_DATE;
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (adv) begin
					// Drop out as soon as the year leaves the legal range.
					if (wrap_fail) begin
						fin     = 1'b1;
						fin_st  = STAT_RANGE;
						state_d = ST_DONE;
					end
				end else begin
					fin     = 1'b1;
					fin_st  = over_max ? STAT_RANGE : STAT_OK;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			// Capture the transaction and take the offset magnitude.
			y_in_q  <= start_year;
			m_in_q  <= start_month;
			d_in_q  <= start_day;
			y_q     <= YWALK_W'(start_year);
			m_q     <= start_month;
			d_q     <= start_day;
			neg_q   <= day_offset[OFFSET_BITS-1];
			mag_q   <= day_offset[OFFSET_BITS-1] ?
				$unsigned(-day_offset) : $unsigned(day_offset);
			fresh_q <= 1'b1;
			rem_q   <= start_year;
			red_k_q <= RED_W'(RED_STEPS - 1);
		end

		if (state_q == ST_REDUCE) begin
			// One restoring step of year mod 400.
			rem_q   <= rem_next;
			yc_q    <= rem_next[CYC_W-1:0];
			red_k_q <= red_k_q - 1'b1;
		end

		if (state_q == ST_WALK && adv && !wrap_fail) begin
			// Advance one month in the walk direction.
			mag_q   <= alu_diff[OFFSET_BITS-1:0];
			fresh_q <= 1'b0;
			if (neg_q) begin
				if (m_q == MONTH_W'(JAN)) begin
					m_q  <= MONTH_W'(MONTHS);
					y_q  <= y_dn;
					yc_q <= (yc_q == '0) ? CYC_W'(CYCLE_YEARS - 1) : yc_q - 1'b1;
				end else begin
					m_q <= m_q - 1'b1;
				end
			end else begin
				if (m_q == MONTH_W'(MONTHS)) begin
					m_q  <= MONTH_W'(JAN);
					y_q  <= y_up;
					yc_q <= (yc_q == CYC_W'(CYCLE_YEARS - 1)) ? '0 : yc_q + 1'b1;
				end else begin
					m_q <= m_q + 1'b1;
				end
			end
		end

		if (fin) begin
			// Hold the result for the strobe; pass the input through on error.
			status_q <= fin_st;
			if (fin_st == STAT_OK) begin
				res_year_q  <= y_q[YEAR_W-1:0];
				res_month_q <= m_q;
				res_day_q   <= end_d;
			end else begin
				res_year_q  <= y_in_q;
				res_month_q <= m_in_q;
				res_day_q   <= d_in_q;
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_DONE);
	assign result_year  = res_year_q;
	assign result_month = res_month_q;
	assign result_day   = res_day_q;
	assign status       = status_q;

endmodule

// File: hdl/gda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_checker: port-level checks for the date add-days block
// Watches the command handshake and the result strobe on the top level.
// ----------------------------------------------------------------------------
module gda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [gda_pkg::MONTH_W-1:0]   result_month,
	input logic [gda_pkg::DAY_W-1:0]     result_day,
	input logic [gda_pkg::STATUS_W-1:0]  status
);
	import gda_pkg::*;

	// A started transaction must hold the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted without busy");

	// The result strobe lasts one cycle only.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// No result appears while the block is idle.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_BAD_DATE || status == STAT_RANGE))
		else $error("undefined status code");

	// A good result is always a real calendar position.
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_OK) |->
		(result_month != '0 && result_month <= MONTH_W'(MONTHS) && result_day != '0))
		else $error("ok result with impossible month or day");

endmodule

bind gregorian_date_add_days_top gda_checker u_gda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_month (result_month),
	.result_day   (result_day),
	.status       (status)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Gregorian date add-days block
// Drives dates and signed day offsets through the start/busy command port,
// predicts every result with an independent month-by-month calendar walk and
// compares each done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import gda_pkg::*;

	// Mostly short hops keep the run quick; a handful of full-range
	// offsets walk ~34,500 months each. The limit covers several times
	// the worst draw of that mix plus all sender gaps.
	localparam int    RANDOM_ITEMS  = 1926;
	localparam int    DIRECTED_ROWS = 24;
	localparam int    DRAIN_CYCLES  = 16;
	localparam int    MAX_PRINTS    = 40;
	localparam longint TIMEOUT_NS   = 100_000_000;

	typedef struct packed {
		logic [YEAR_W-1:0]             year;
		logic [MONTH_W-1:0]            month;
		logic [DAY_W-1:0]              day;
		logic signed [OFFSET_BITS-1:0] offset;
	} date_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		status_t            status;
	} date_result_t;

	// One directed transaction; typed rows carry a hand-written answer.
	typedef struct {
		int      year;
		int      month;
		int      day;
		int      offset;
		bit      typed;
		int      exp_year;
		int      exp_month;
		int      exp_day;
		status_t exp_status;
	} directed_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [YEAR_W-1:0]             start_year;
	logic [MONTH_W-1:0]            start_month;
	logic [DAY_W-1:0]              start_day;
	logic signed [OFFSET_BITS-1:0] day_offset;
	logic                          done;
	logic [YEAR_W-1:0]             result_year;
	logic [MONTH_W-1:0]            result_month;
	logic [DAY_W-1:0]              result_day;
	logic [STATUS_W-1:0]           status;

	date_result_t pending_dates[$];

	int mismatch_count = 0;
	int results_seen   = 0;
	int items_sent     = 0;
	int good_count     = 0;
	int invalid_count  = 0;
	int range_count    = 0;
	int longest_walk   = 0;

	// Extremes, leap rules, each status, the over-range input year, zero and
	// most negative offsets. Rows with typed = 0 go through the predictor.
	directed_row_t dir_table [DIRECTED_ROWS] = '{
		'{ 2000,  2, 29,        0, 1'b1,  2000,  2, 29, STAT_OK},
		'{ 1900,  2, 29,        5, 1'b1,  1900,  2, 29, STAT_BAD_DATE},
		'{    0,  1,  1,        5, 1'b1,     0,  1,  1, STAT_BAD_DATE},
		'{ 2023,  0, 10,        1, 1'b1,  2023,  0, 10, STAT_BAD_DATE},
		'{16383, 15, 31,       -1, 1'b1, 16383, 15, 31, STAT_BAD_DATE},
		'{ 2023,  4, 31,        0, 1'b1,  2023,  4, 31, STAT_BAD_DATE},
		'{ 2023,  6,  0,        3, 1'b1,  2023,  6,  0, STAT_BAD_DATE},
		'{    1,  1,  1,       -1, 1'b1,     1,  1,  1, STAT_RANGE},
		'{ 9999, 12, 31,        1, 1'b1,  9999, 12, 31, STAT_RANGE},
		'{10000,  1,  1,        0, 1'b1, 10000,  1,  1, STAT_RANGE},
		'{ 9999, 12, 31,        0, 1'b1,  9999, 12, 31, STAT_OK},
		'{    1,  1,  1,        0, 1'b1,     1,  1,  1, STAT_OK},
		'{ 2024,  2, 28,        1, 1'b0,     0,  0,  0, STAT_OK},
		'{ 2100,  2, 28,        1, 1'b0,     0,  0,  0, STAT_OK},
		'{ 1600,  3,  1,       -1, 1'b0,     0,  0,  0, STAT_OK},
		'{ 2023, 12, 31,        1, 1'b0,     0,  0,  0, STAT_OK},
		'{ 2023,  1,  1,       -1, 1'b0,     0,  0,  0, STAT_OK},
		'{    1,  1,  1,  1048575, 1'b0,     0,  0,  0, STAT_OK},
		'{ 9999, 12, 31, -1048575, 1'b0,     0,  0,  0, STAT_OK},
		'{ 5000,  6, 15, -1048576, 1'b0,     0,  0,  0, STAT_OK},
		'{16383, 12, 31, -1048576, 1'b0,     0,  0,  0, STAT_OK},
		'{12000,  3,  1, -1048575, 1'b0,     0,  0,  0, STAT_OK},
		'{ 9000,  1, 31,  1048575, 1'b0,     0,  0,  0, STAT_OK},
		'{ 2023,  7,  4, -1048575, 1'b0,     0,  0,  0, STAT_OK}
	};

	gregorian_date_add_days_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.day_offset   (day_offset),
		.done         (done),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------------

	// Gregorian month length; leap when divisible by 4 and not by 100,
	// or divisible by 400. Months outside 1..12 have no days.
	function automatic int month_days(input int y, input int m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Walk one month at a time from the start date; months_walked reports
	// how many month boundaries the walk crossed.
	function automatic date_result_t add_days(input date_req_t req,
			output int months_walked);
		longint       y;
		longint       d;
		longint       mag;
		longint       ofs;
		int           m;
		bit           neg;
		status_t      st;
		date_result_t res;

		y   = req.year;
		m   = req.month;
		d   = req.day;
		ofs = $signed(req.offset);
		neg = ofs < 0;
		mag = neg ? -ofs : ofs;
		st  = STAT_OK;
		months_walked = 0;

		if (y == 0 || m < 1 || m > 12 || d < 1 || d > month_days(int'(y), m)) begin
			st = STAT_BAD_DATE;
		end else if (!neg) begin
			// Advance to the first day of the next month until the rest fits.
			while (d + mag > month_days(int'(y), m)) begin
				mag -= month_days(int'(y), m) - d;
				d = 0;
				months_walked++;
				if (m == 12) begin
					y++;
					m = 0;
					if (y > MAX_YEAR) begin
						st = STAT_RANGE;
						break;
					end
				end
				m++;
			end
			if (st == STAT_OK)
				d += mag;
		end else begin
			// Drop back to the last day of the previous month.
			while (d <= mag) begin
				mag -= d;
				months_walked++;
				if (m == 1) begin
					m = 13;
					y--;
					if (y < 1) begin
						st = STAT_RANGE;
						break;
					end
				end
				m--;
				d = month_days(int'(y), m);
			end
			if (st == STAT_OK)
				d -= mag;
		end

		// An input year above the limit can survive a short walk: catch it here.
		if (st == STAT_OK && (y < 1 || y > MAX_YEAR))
			st = STAT_RANGE;

		if (st != STAT_OK) begin
			res.year  = req.year;
			res.month = req.month;
			res.day   = req.day;
		end else begin
			res.year  = YEAR_W'(y);
			res.month = MONTH_W'(m);
			res.day   = DAY_W'(d);
		end
		res.status = st;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Random stimulus
	// ------------------------------------------------------------------------

	// Mostly well-formed dates with short offsets; a few broken dates, raw
	// noise and full-range offsets.
	function automatic date_req_t make_random_date();
		date_req_t req;
		int        pick;
		int        y;
		int        m;
		int        lim;
		int        mag;
		int        ofs;
		bit        neg;

		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			// Raw noise on the date, short hop so a valid draw stays quick.
			req.year   = YEAR_W'($urandom);
			req.month  = MONTH_W'($urandom);
			req.day    = DAY_W'($urandom);
			ofs        = int'($urandom_range(0, 2000)) - 1000;
			req.offset = OFFSET_BITS'(ofs);
			return req;
		end
		if (pick < 10) begin
			// Broken date with any offset bits: returns at once.
			y = $urandom_range(1, 16383);
			m = $urandom_range(1, 12);
			req.day = DAY_W'($urandom_range(1, 28));
			case ($urandom_range(0, 3))
				0: y = 0;
				1: m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
				2: req.day = '0;
				default: begin
					case ($urandom_range(0, 4))
						0: m = 2;
						1: m = 4;
						2: m = 6;
						3: m = 9;
						default: m = 11;
					endcase
					req.day = DAY_W'($urandom_range(month_days(y, m) + 1, 31));
				end
			endcase
			req.year   = YEAR_W'(y);
			req.month  = MONTH_W'(m);
			req.offset = OFFSET_BITS'($urandom);
			return req;
		end

		pick = $urandom_range(0, 99);
		if (pick < 70)
			y = $urandom_range(1, MAX_YEAR);
		else if (pick < 80)
			y = $urandom_range(1, 5);
		else if (pick < 90)
			y = $urandom_range(MAX_YEAR - 4, MAX_YEAR);
		else if (pick < 95)
			y = 100 * $urandom_range(1, 99);
		else
			y = $urandom_range(MAX_YEAR + 1, 16383);
		m = $urandom_range(1, 12);
		req.year  = YEAR_W'(y);
		req.month = MONTH_W'(m);
		if ($urandom_range(0, 4) == 0)
			req.day = DAY_W'(month_days(y, m));
		else
			req.day = DAY_W'($urandom_range(1, month_days(y, m)));

		// Keep full-range walks rare: each one walks tens of thousands of months.
		pick = $urandom_range(0, 199);
		neg  = $urandom_range(0, 1);
		if (pick < 124)
			lim = 400;
		else if (pick < 174)
			lim = 4000;
		else if (pick < 197)
			lim = 40000;
		else
			lim = neg ? 1048576 : 1048575;
		mag = $urandom_range(0, lim);
		ofs = neg ? -mag : mag;
		req.offset = OFFSET_BITS'(ofs);
		return req;
	endfunction

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// Tally the expected outcome so the summary can tell what was covered.
	task automatic note_expectation(input date_result_t want, input int walked);
		case (want.status)
			STAT_OK:       good_count++;
			STAT_BAD_DATE: invalid_count++;
			default:       range_count++;
		endcase
		if (walked > longest_walk)
			longest_walk = walked;
	endtask

	// Hold start and the fields until an edge finds busy low: that edge
	// accepts the transaction. Leave start high so a next call can chain.
	task automatic send_date(input date_req_t req, input date_result_t want);
		start       <= 1'b1;
		start_year  <= req.year;
		start_month <= req.month;
		start_day   <= req.day;
		day_offset  <= req.offset;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_dates.push_back(want);
		items_sent++;
	endtask

	// Drop start for a randomly drawn gap.
	task automatic pause_sender();
		int gap;
		gap = $urandom_range(1, 11);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	initial begin
		date_req_t    req;
		date_result_t want;
		int           walked;
		bit           idle_on;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		start_year  <= '0;
		start_month <= '0;
		start_day   <= '0;
		day_offset  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: typed rows check the obvious answers directly.
		foreach (dir_table[i]) begin
			req.year   = YEAR_W'(dir_table[i].year);
			req.month  = MONTH_W'(dir_table[i].month);
			req.day    = DAY_W'(dir_table[i].day);
			req.offset = OFFSET_BITS'(dir_table[i].offset);
			if (dir_table[i].typed) begin
				want.year   = YEAR_W'(dir_table[i].exp_year);
				want.month  = MONTH_W'(dir_table[i].exp_month);
				want.day    = DAY_W'(dir_table[i].exp_day);
				want.status = dir_table[i].exp_status;
				walked      = 0;
			end else begin
				want = add_days(req, walked);
			end
			note_expectation(want, walked);
			send_date(req, want);
			if ($urandom_range(0, 2) == 0)
				pause_sender();
		end

		// Random part: idling comes and goes in stretches, none at the tail.
		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 9) < 7);
			if (n >= RANDOM_ITEMS * 9 / 10)
				idle_on = 1'b0;
			req  = make_random_date();
			want = add_days(req, walked);
			note_expectation(want, walked);
			send_date(req, want);
			if (idle_on && $urandom_range(0, 2) == 0)
				pause_sender();
		end
		start <= 1'b0;

		// Drain outstanding results, then give the block time to misbehave.
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions: %0d valid results, %0d invalid dates, %0d out of range",
			items_sent, good_count, invalid_count, range_count);
		$display("Longest predicted walk %0d months; %0d results checked, %0d mismatches",
			longest_walk, results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result checker: done marks one cycle, accepted at the edge ending it
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		date_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
					result_year, result_month, result_day, status));
			end else begin
				want = pending_dates.pop_front();
				if (result_year !== want.year)
					report_mismatch($sformatf("result %0d: year %0d, expected %0d",
						results_seen, result_year, want.year));
				if (result_month !== want.month)
					report_mismatch($sformatf("result %0d: month %0d, expected %0d",
						results_seen, result_month, want.month));
				if (result_day !== want.day)
					report_mismatch($sformatf("result %0d: day %0d, expected %0d",
						results_seen, result_day, want.day));
				if (status !== want.status)
					report_mismatch($sformatf("result %0d: status %0d, expected %s",
						results_seen, status, want.status.name()));
				results_seen++;
			end
		end else if (arst_n === 1'b1 && $isunknown(done)) begin
			report_mismatch("done strobe unknown after reset");
		end
	end

	// Hard stop if the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
